[hdl/hsp_pkg.sv]
// Shared types, constants and helpers for the HTTP status/header parser.
// No dependencies; imported by every module of the block.
package hsp_pkg;

    localparam int MAX_BYTES = 16384;
    localparam int POS_W     = $clog2(MAX_BYTES);
    localparam int FIELD_W   = 14;
    localparam int NUM_W     = 16;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    // event kinds
    localparam logic [2:0] EV_VERSION  = 3'd0;
    localparam logic [2:0] EV_STATUS   = 3'd1;
    localparam logic [2:0] EV_PHRASE   = 3'd2;
    localparam logic [2:0] EV_HDR_NAME = 3'd3;
    localparam logic [2:0] EV_HDR_VAL  = 3'd4;
    localparam logic [2:0] EV_COMPLETE = 3'd5;
    localparam logic [2:0] EV_ERROR    = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_VERSION  = 3'd1;
    localparam logic [2:0] ERR_SHORT    = 3'd2;
    localparam logic [2:0] ERR_LONE_CR  = 3'd3;
    localparam logic [2:0] ERR_HDR_NAME = 3'd4;
    localparam logic [2:0] ERR_HDR_MAX  = 3'd5;
    localparam logic [2:0] ERR_TOO_LONG = 3'd6;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;

    localparam logic [2:0] VER_LEN = 3'd7;

    // classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0]       data;
        logic             first;
        logic             is_ws;
        logic             is_cr;
        logic             is_lf;
        logic             is_colon;
        logic [NUM_W-1:0] dig100;
        logic [NUM_W-1:0] dig10;
        logic [NUM_W-1:0] dig1;
    } t_item;

    // "HTTP/1." prefix
    function automatic logic [7:0] ver_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2f;
            3'd5:    c = 8'h31;
            3'd6:    c = 8'h2e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hdl/hsp_front.sv]
// Front end: takes input bytes and classifies them for the parser back end.
// Depends on hsp_pkg.
module hsp_front import hsp_pkg::*; (
    input  logic       i_in_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_first,
    input  logic       i_q_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_item      o_item
);

    logic [NUM_W-1:0] w_digit;

    assign w_digit = {{(NUM_W-8){1'b0}}, i_data_byte} - {{(NUM_W-8){1'b0}}, CH_ZERO};

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

    always_comb begin
        o_item.data     = i_data_byte;
        o_item.first    = i_first;
        o_item.is_cr    = (i_data_byte == CH_CR);
        o_item.is_lf    = (i_data_byte == CH_LF);
        o_item.is_ws    = (i_data_byte == CH_SP) || (i_data_byte == CH_TAB) ||
                          (i_data_byte == CH_CR) || (i_data_byte == CH_LF);
        o_item.is_colon = (i_data_byte == CH_COLON);
        // no digit check: wraps for non-digits, as the code is defined
        o_item.dig100   = NUM_W'(w_digit * NUM_W'(100));
        o_item.dig10    = NUM_W'(w_digit * NUM_W'(10));
        o_item.dig1     = w_digit;
    end

endmodule

[hdl/hsp_queue.sv]
// Short item queue between the classifying front end and the parser.
// Depends on hsp_pkg.
module hsp_queue import hsp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_count;
    logic            w_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rp];
    assign w_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/hsp_back.sv]
// Back end: response parser state machine, header limit register and
// registered result stage. Depends on hsp_pkg.
module hsp_back import hsp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  t_item               i_item,
    output logic                o_pop,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_event_kind,
    output logic [FIELD_W-1:0]  o_field_start,
    output logic [FIELD_W-1:0]  o_field_length,
    output logic signed [15:0]  o_number,
    output logic [2:0]          o_error_code
);

    typedef enum logic [10:0] {
        PH_VERSION     = 11'b000_0000_0001,
        PH_STATUS_SKIP = 11'b000_0000_0010,
        PH_STATUS_TOK  = 11'b000_0000_0100,
        PH_PHRASE_SKIP = 11'b000_0000_1000,
        PH_PHRASE      = 11'b000_0001_0000,
        PH_WAIT_LF     = 11'b000_0010_0000,
        PH_HDR_START   = 11'b000_0100_0000,
        PH_NAME_SKIP   = 11'b000_1000_0000,
        PH_NAME_TOK    = 11'b001_0000_0000,
        PH_VALUE_SKIP  = 11'b010_0000_0000,
        PH_VALUE       = 11'b100_0000_0000
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_tok, n_tok;
    logic [2:0]       r_vidx, n_vidx;
    logic [NUM_W-1:0] r_sval, n_sval;
    logic [1:0]       r_dcnt, n_dcnt;
    logic [7:0]       r_hcnt, n_hcnt;
    logic             r_scr, n_scr;
    logic             r_colon, n_colon;
    logic             r_fin, n_fin;
    logic [7:0]       r_hdr_limit;

    logic               r_out_valid;
    logic [2:0]         r_kind;
    logic [FIELD_W-1:0] r_start;
    logic [FIELD_W-1:0] r_len;
    logic [NUM_W-1:0]   r_number;
    logic [2:0]         r_err;

    logic               w_advance;
    logic               w_deq;
    logic [POS_W-1:0]   w_p;
    logic               e_emit;
    logic [2:0]         e_kind;
    logic [POS_W-1:0]   e_start;
    logic [POS_W-1:0]   e_len;
    logic [NUM_W-1:0]   e_num;
    logic [2:0]         e_err;

    assign w_advance   = ~r_out_valid | ~i_out_stall;
    assign w_deq       = w_advance & ~i_q_empty;
    assign o_pop       = w_deq;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_tok   = r_tok;
        n_vidx  = r_vidx;
        n_sval  = r_sval;
        n_dcnt  = r_dcnt;
        n_hcnt  = r_hcnt;
        n_scr   = r_scr;
        n_colon = r_colon;
        n_fin   = r_fin;
        w_p     = r_pos;
        e_emit  = 1'b0;
        e_kind  = EV_ERROR;
        e_start = '0;
        e_len   = '0;
        e_num   = '0;
        e_err   = ERR_NONE;

        if (w_deq) begin
            if (i_item.first) begin
                n_phase = PH_VERSION;
                n_pos   = '0;
                n_tok   = '0;
                n_vidx  = '0;
                n_sval  = '0;
                n_dcnt  = '0;
                n_hcnt  = '0;
                n_scr   = 1'b0;
                n_colon = 1'b0;
                n_fin   = 1'b0;
            end
            w_p = n_pos;
            if (!n_fin) begin
                if (w_p >= POS_W'(MAX_BYTES - 1)) begin
                    n_fin   = 1'b1;
                    e_emit  = 1'b1;
                    e_start = w_p;
                    e_err   = ERR_TOO_LONG;
                end else begin
                    n_pos = w_p + 1'b1;
                    case (n_phase)
                        PH_VERSION: begin
                            if (n_vidx < VER_LEN) begin
                                if (i_item.data != ver_char(n_vidx)) begin
                                    n_fin   = 1'b1;
                                    e_emit  = 1'b1;
                                    e_start = w_p;
                                    e_err   = ERR_VERSION;
                                end else begin
                                    n_vidx = n_vidx + 1'b1;
                                end
                            end else if (i_item.data == CH_ZERO || i_item.data == CH_ONE) begin
                                n_phase = PH_STATUS_SKIP;
                                e_emit  = 1'b1;
                                e_kind  = EV_VERSION;
                                e_len   = POS_W'(8);
                                e_num   = {{(NUM_W-1){1'b0}}, i_item.data[0]};
                            end else begin
                                n_fin   = 1'b1;
                                e_emit  = 1'b1;
                                e_start = w_p;
                                e_err   = ERR_VERSION;
                            end
                        end
                        PH_STATUS_SKIP: begin
                            if (!i_item.is_ws) begin
                                n_tok   = w_p;
                                n_sval  = i_item.dig100;
                                n_dcnt  = 2'd1;
                                n_phase = PH_STATUS_TOK;
                            end
                        end
                        PH_STATUS_TOK: begin
                            if (!i_item.is_ws) begin
                                case (n_dcnt)
                                    2'd0:    n_sval = i_item.dig100;
                                    2'd1:    n_sval = n_sval + i_item.dig10;
                                    2'd2:    n_sval = n_sval + i_item.dig1;
                                    default: n_sval = n_sval;
                                endcase
                                if (n_dcnt != 2'd3) begin
                                    n_dcnt = n_dcnt + 1'b1;
                                end
                            end else if (n_dcnt != 2'd3) begin
                                n_fin   = 1'b1;
                                e_emit  = 1'b1;
                                e_start = w_p;
                                e_err   = ERR_SHORT;
                            end else begin
                                n_phase = PH_PHRASE_SKIP;
                                e_emit  = 1'b1;
                                e_kind  = EV_STATUS;
                                e_start = n_tok;
                                e_len   = w_p - n_tok;
                                e_num   = n_sval;
                            end
                        end
                        PH_PHRASE_SKIP, PH_VALUE_SKIP: begin
                            if (!i_item.is_ws) begin
                                n_tok   = w_p;
                                n_phase = (n_phase == PH_PHRASE_SKIP) ? PH_PHRASE : PH_VALUE;
                            end
                        end
                        PH_PHRASE, PH_VALUE: begin
                            if (i_item.is_cr || i_item.is_lf) begin
                                e_emit  = 1'b1;
                                e_kind  = (n_phase == PH_PHRASE) ? EV_PHRASE : EV_HDR_VAL;
                                e_start = n_tok;
                                e_len   = w_p - n_tok;
                                if (n_phase == PH_VALUE) begin
                                    n_hcnt = n_hcnt + 1'b1;
                                end
                                n_scr   = 1'b0;
                                n_phase = i_item.is_cr ? PH_WAIT_LF : PH_HDR_START;
                            end
                        end
                        PH_WAIT_LF: begin
                            if (!i_item.is_lf) begin
                                n_fin   = 1'b1;
                                e_emit  = 1'b1;
                                e_start = w_p;
                                e_err   = ERR_LONE_CR;
                            end else if (n_scr) begin
                                n_fin  = 1'b1;
                                e_emit = 1'b1;
                                e_kind = EV_COMPLETE;
                                e_len  = w_p + 1'b1;
                                e_num  = {{(NUM_W-8){1'b0}}, n_hcnt};
                            end else begin
                                n_phase = PH_HDR_START;
                            end
                        end
                        PH_HDR_START: begin
                            if (i_item.is_cr) begin
                                n_scr   = 1'b1;
                                n_phase = PH_WAIT_LF;
                            end else if (i_item.is_lf) begin
                                n_fin  = 1'b1;
                                e_emit = 1'b1;
                                e_kind = EV_COMPLETE;
                                e_len  = w_p + 1'b1;
                                e_num  = {{(NUM_W-8){1'b0}}, n_hcnt};
                            end else if (n_hcnt >= r_hdr_limit) begin
                                n_fin   = 1'b1;
                                e_emit  = 1'b1;
                                e_start = w_p;
                                e_err   = ERR_HDR_MAX;
                            end else if (i_item.is_ws) begin
                                n_phase = PH_NAME_SKIP;
                            end else begin
                                n_tok   = w_p;
                                n_colon = i_item.is_colon;
                                n_phase = PH_NAME_TOK;
                            end
                        end
                        PH_NAME_SKIP: begin
                            if (!i_item.is_ws) begin
                                n_tok   = w_p;
                                n_colon = i_item.is_colon;
                                n_phase = PH_NAME_TOK;
                            end
                        end
                        PH_NAME_TOK: begin
                            if (!i_item.is_ws) begin
                                n_colon = i_item.is_colon;
                            end else if (!n_colon) begin
                                n_fin   = 1'b1;
                                e_emit  = 1'b1;
                                e_start = w_p;
                                e_err   = ERR_HDR_NAME;
                            end else begin
                                n_phase = PH_VALUE_SKIP;
                                e_emit  = 1'b1;
                                e_kind  = EV_HDR_NAME;
                                e_start = n_tok;
                                // colon is not part of the name
                                e_len   = w_p - n_tok - 1'b1;
                            end
                        end
                        default: begin
                            n_fin = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_VERSION;
            r_pos       <= '0;
            r_tok       <= '0;
            r_vidx      <= '0;
            r_sval      <= '0;
            r_dcnt      <= '0;
            r_hcnt      <= '0;
            r_scr       <= 1'b0;
            r_colon     <= 1'b0;
            r_fin       <= 1'b1;
            r_hdr_limit <= 8'd32;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_tok   <= n_tok;
            r_vidx  <= n_vidx;
            r_sval  <= n_sval;
            r_dcnt  <= n_dcnt;
            r_hcnt  <= n_hcnt;
            r_scr   <= n_scr;
            r_colon <= n_colon;
            r_fin   <= n_fin;
            if (i_cfg_valid) begin
                r_hdr_limit <= i_cfg_data;
            end
            if (w_advance) begin
                r_out_valid <= w_deq & e_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_deq && e_emit) begin
            r_kind   <= e_kind;
            r_start  <= FIELD_W'(e_start);
            r_len    <= FIELD_W'(e_len);
            r_number <= e_num;
            r_err    <= e_err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_kind;
    assign o_field_start  = r_start;
    assign o_field_length = r_len;
    assign o_number       = $signed(r_number);
    assign o_error_code   = r_err;

    a_err_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == EV_ERROR) |-> (r_err != ERR_NONE))
        else $error("error item without a code");

    a_ok_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != EV_ERROR) |-> (r_err == ERR_NONE))
        else $error("non-error item carries an error code");

    a_end_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_deq && e_emit && (e_kind == EV_ERROR || e_kind == EV_COMPLETE)) |=> r_fin)
        else $error("parser not idle after complete or error");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_BYTES - 1))
        else $error("byte position past limit");

endmodule

[hdl/http_status_header_parser.sv]
// Top level of the HTTP response head parser: front end, item queue, back end.
// Depends on hsp_pkg, hsp_front, hsp_queue, hsp_back.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------------
//  in       | in        | i_in_valid / o_in_stall  | i_data_byte, i_first
//  out      | out       | o_out_valid / i_out_stall| o_event_kind, o_field_start,
//           |           |                          | o_field_length, o_number, o_error_code
//  cfg      | in        | i_cfg_valid / o_cfg_ready| i_cfg_data (header limit)
//
// One byte per cycle sustained while the queue is not full; a byte is written to the queue
// when accepted, and its result, at most one, is registered when the back end pops it.
// The 4-entry queue lets the front keep taking bytes while the result register stalls.
// Synchronous active-low reset; after reset the parser idles until a byte with i_first.
// o_cfg_ready is always high.
module http_status_header_parser import hsp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_first,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_event_kind,
    output logic [13:0]         o_field_start,
    output logic [13:0]         o_field_length,
    output logic signed [15:0]  o_number,
    output logic [2:0]          o_error_code,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_item w_front_item;
    t_item w_back_item;

    hsp_front u_front (
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_first     (i_first),
        .i_q_full    (w_full),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    hsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_back_item)
    );

    hsp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_empty),
        .i_item         (w_back_item),
        .o_pop          (w_pop),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_kind   (o_event_kind),
        .o_field_start  (o_field_start),
        .o_field_length (o_field_length),
        .o_number       (o_number),
        .o_error_code   (o_error_code)
    );

endmodule
